### sv/imu_offset_calibrator_defines.svh
// assertion macros for the imu offset calibrator
`ifndef IMU_OFFSET_CALIBRATOR_DEFINES_SVH
`define IMU_OFFSET_CALIBRATOR_DEFINES_SVH

// same-cycle implication, sampled on aclk, off during reset
`define IOC_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on aclk, off during reset
`define IOC_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/imu_oc_pkg.sv
package imu_oc_pkg;

    // word layout
    localparam int AXIS_W  = 16;
    localparam int TEMP_W  = 9;
    localparam int SUM_W   = 24;
    localparam int CNT_W   = 8;
    localparam int DATA_W  = 112;
    localparam int USER_W  = 2;

    // samples averaged per calibration, 1 to 255
    localparam int CAL_SAMPLES = 200;

    // temperature scaling: raw / 340 + 36
    localparam int TEMP_DIV    = 340;
    localparam int TEMP_BIAS   = 36;
    localparam int TEMP_MAG_W  = 17;
    localparam int TEMP_K      = 16 + $clog2(TEMP_DIV);
    localparam longint unsigned TEMP_RECIP =
        ((64'd1 << TEMP_K) + TEMP_DIV - 1) / TEMP_DIV;
    localparam int TEMP_RECIP_W = 17;
    localparam int TEMP_PROD_W  = TEMP_MAG_W + TEMP_RECIP_W;
    localparam int TEMP_Q_W     = 8;

    // offset averaging: sum / CAL_SAMPLES by reciprocal multiply
    localparam int DIV_K        = SUM_W + $clog2(CAL_SAMPLES);
    localparam longint unsigned DIV_RECIP =
        ((64'd1 << DIV_K) + CAL_SAMPLES - 1) / CAL_SAMPLES;
    localparam int DIV_RECIP_W  = SUM_W + 1;
    localparam int DIV_PROD_W   = SUM_W + DIV_RECIP_W;

    // tuser bits
    localparam int USER_GYRO  = 0;
    localparam int USER_ACCEL = 1;

    typedef logic signed [AXIS_W-1:0] axis_t;
    typedef logic signed [SUM_W-1:0]  sum_t;
    typedef logic [CNT_W-1:0]         cnt_t;

    // truncating divide by 340 plus bias, exact over the 16-bit input range
    function automatic logic signed [TEMP_W-1:0] temp_convert(input axis_t raw);
        logic                     neg;
        logic [TEMP_MAG_W-1:0]    mag;
        logic [TEMP_PROD_W-1:0]   prod;
        logic [TEMP_Q_W-1:0]      q;
        logic signed [TEMP_W-1:0] qs;
        neg  = raw[AXIS_W-1];
        mag  = neg ? (TEMP_MAG_W'(0) - TEMP_MAG_W'(raw)) : TEMP_MAG_W'(raw);
        prod = TEMP_PROD_W'(mag) * TEMP_PROD_W'(TEMP_RECIP);
        q    = TEMP_Q_W'(prod >> TEMP_K);
        qs   = neg ? (TEMP_W'(0) - TEMP_W'(q)) : TEMP_W'(q);
        return qs + TEMP_W'(TEMP_BIAS);
    endfunction

endpackage

### sv/imu_offset_calibrator.sv
// path: a word accepted on s_ passes through the input register and then the result register to m_
// throughput: one word per cycle while m_tready is high; after the last sample of a calibration the input
//   stalls while the shared reciprocal-multiply divider (pending stage, write stage) writes the new offsets
// reset: aresetn, synchronous active low, clears offsets, sums, counters, busy flags, valids
`include "imu_offset_calibrator_defines.svh"

module imu_offset_calibrator
    import imu_oc_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    // raw_accel_x, raw_accel_y, raw_accel_z, raw_temperature, raw_gyro_x, raw_gyro_y, raw_gyro_z
    input  logic [DATA_W-1:0] s_tdata,
    // request_gyro_cal, request_accel_cal
    input  logic [USER_W-1:0] s_tuser,
    output logic              m_tvalid,
    input  logic              m_tready,
    // accel_x, accel_y, accel_z, temperature_c, gyro_x, gyro_y, gyro_z, zero pad
    output logic [DATA_W-1:0] m_tdata,
    // gyro_cal_busy, accel_cal_busy
    output logic [USER_W-1:0] m_tuser
);

    // pipeline registers
    logic              in_valid_reg;
    logic [DATA_W-1:0] in_data_reg;
    logic [USER_W-1:0] in_user_reg;
    logic              out_valid_reg;
    logic [DATA_W-1:0] out_data_reg, out_data_next;
    logic [USER_W-1:0] out_user_reg, out_user_next;

    // calibration state
    axis_t g_off_reg [3];
    axis_t g_off_next [3];
    axis_t a_off_reg [3];
    axis_t a_off_next [3];
    sum_t  g_sum_reg [3];
    sum_t  g_sum_next [3];
    sum_t  a_sum_reg [3];
    sum_t  a_sum_next [3];
    cnt_t  g_cnt_reg, g_cnt_next;
    cnt_t  a_cnt_reg, a_cnt_next;
    logic  g_flag_reg, g_flag_next;
    logic  a_flag_reg, a_flag_next;

    // offset divider
    logic                  div_pend_reg, div_pend_next;
    logic                  div_gyro_reg, div_gyro_next;
    logic                  div_wr_reg;
    logic                  div_wr_gyro_reg;
    logic [DIV_PROD_W-1:0] div_prod_reg [3];
    logic [DIV_PROD_W-1:0] div_prod_next [3];
    logic                  div_neg_reg [3];
    logic                  div_neg_next [3];
    sum_t                  div_sel [3];
    logic [SUM_W-1:0]      div_mag [3];
    logic [SUM_W-1:0]      div_q [3];
    sum_t                  div_qs [3];

    // datapath
    logic  fire, out_free, div_busy;
    logic  g_cal, a_cal, skip_accel, div_start;
    axis_t raw_a [3];
    axis_t raw_g [3];
    axis_t acc [3];
    axis_t gyr [3];
    logic signed [TEMP_W-1:0] temp_c;

    // handshake
    assign div_busy = div_pend_reg || div_wr_reg;
    assign out_free = !out_valid_reg || m_tready;
    assign fire     = in_valid_reg && out_free && !div_busy;
    assign s_tready = !in_valid_reg || fire;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

    // unpack and correct
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            raw_a[i] = in_data_reg[AXIS_W*i +: AXIS_W];
            raw_g[i] = in_data_reg[AXIS_W*(4+i) +: AXIS_W];
            acc[i]   = raw_a[i] - a_off_reg[i];
            gyr[i]   = raw_g[i] - g_off_reg[i];
        end
        temp_c = temp_convert(in_data_reg[AXIS_W*3 +: AXIS_W]);
    end

    // divider: magnitude times reciprocal, then quotient and sign from the registered product
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            div_sel[i]       = div_gyro_reg ? g_sum_reg[i] : a_sum_reg[i];
            div_neg_next[i]  = div_sel[i][SUM_W-1];
            div_mag[i]       = div_neg_next[i] ? (SUM_W'(0) - SUM_W'(div_sel[i]))
                                               : SUM_W'(div_sel[i]);
            div_prod_next[i] = DIV_PROD_W'(div_mag[i]) * DIV_PROD_W'(DIV_RECIP);
            div_q[i]         = SUM_W'(div_prod_reg[i] >> DIV_K);
            div_qs[i]        = div_neg_reg[i] ? (SUM_W'(0) - div_q[i]) : div_q[i];
        end
    end

    // calibration step
    always_comb begin
        g_off_next    = g_off_reg;
        a_off_next    = a_off_reg;
        g_sum_next    = g_sum_reg;
        a_sum_next    = a_sum_reg;
        g_cnt_next    = g_cnt_reg;
        a_cnt_next    = a_cnt_reg;
        g_flag_next   = g_flag_reg;
        a_flag_next   = a_flag_reg;
        div_gyro_next = div_gyro_reg;
        skip_accel    = 1'b0;
        div_start     = 1'b0;
        g_cal         = g_flag_reg || in_user_reg[USER_GYRO];
        a_cal         = a_flag_reg || in_user_reg[USER_ACCEL];

        if (fire) begin
            g_flag_next = g_cal;
            a_flag_next = a_cal;
            // gyro first
            if (g_cal) begin
                if (g_cnt_reg == '0) begin
                    for (int i = 0; i < 3; i++) begin
                        g_off_next[i] = '0;
                        g_sum_next[i] = '0;
                    end
                    g_cnt_next = CNT_W'(1);
                    skip_accel = 1'b1;
                end else begin
                    for (int i = 0; i < 3; i++) begin
                        g_sum_next[i] = g_sum_reg[i] + SUM_W'(gyr[i]);
                    end
                    if (g_cnt_reg == CNT_W'(CAL_SAMPLES)) begin
                        g_cnt_next    = '0;
                        g_flag_next   = 1'b0;
                        skip_accel    = 1'b1;
                        div_start     = 1'b1;
                        div_gyro_next = 1'b1;
                    end else begin
                        g_cnt_next = g_cnt_reg + CNT_W'(1);
                    end
                end
            end
            // accel unless the gyro started or finished
            if (!skip_accel && a_cal) begin
                if (a_cnt_reg == '0) begin
                    for (int i = 0; i < 3; i++) begin
                        a_off_next[i] = '0;
                        a_sum_next[i] = '0;
                    end
                    a_cnt_next = CNT_W'(1);
                end else begin
                    for (int i = 0; i < 3; i++) begin
                        a_sum_next[i] = a_sum_reg[i] + SUM_W'(acc[i]);
                    end
                    if (a_cnt_reg == CNT_W'(CAL_SAMPLES)) begin
                        a_cnt_next    = '0;
                        a_flag_next   = 1'b0;
                        div_start     = 1'b1;
                        div_gyro_next = 1'b0;
                    end else begin
                        a_cnt_next = a_cnt_reg + CNT_W'(1);
                    end
                end
            end
        end

        // divider second stage writes the averaged offsets
        if (div_wr_reg) begin
            for (int i = 0; i < 3; i++) begin
                if (div_wr_gyro_reg) begin
                    g_off_next[i] = div_qs[i][AXIS_W-1:0];
                end else begin
                    a_off_next[i] = div_qs[i][AXIS_W-1:0];
                end
            end
        end

        div_pend_next = div_start;
    end

    // result word
    always_comb begin
        out_data_next = '0;
        for (int i = 0; i < 3; i++) begin
            out_data_next[AXIS_W*i +: AXIS_W] = acc[i];
            out_data_next[AXIS_W*3 + TEMP_W + AXIS_W*i +: AXIS_W] = gyr[i];
        end
        out_data_next[AXIS_W*3 +: TEMP_W] = temp_c;
        out_user_next[USER_GYRO]  = g_flag_next;
        out_user_next[USER_ACCEL] = a_flag_next;
    end

    // registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            g_cnt_reg       <= '0;
            a_cnt_reg       <= '0;
            g_flag_reg      <= 1'b0;
            a_flag_reg      <= 1'b0;
            div_pend_reg    <= 1'b0;
            div_gyro_reg    <= 1'b0;
            div_wr_reg      <= 1'b0;
            div_wr_gyro_reg <= 1'b0;
            for (int i = 0; i < 3; i++) begin
                g_off_reg[i] <= '0;
                a_off_reg[i] <= '0;
                g_sum_reg[i] <= '0;
                a_sum_reg[i] <= '0;
            end
        end else begin
            if (s_tvalid && s_tready) begin
                in_valid_reg <= 1'b1;
            end else if (fire) begin
                in_valid_reg <= 1'b0;
            end
            if (fire) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
            g_off_reg       <= g_off_next;
            a_off_reg       <= a_off_next;
            g_sum_reg       <= g_sum_next;
            a_sum_reg       <= a_sum_next;
            g_cnt_reg       <= g_cnt_next;
            a_cnt_reg       <= a_cnt_next;
            g_flag_reg      <= g_flag_next;
            a_flag_reg      <= a_flag_next;
            div_pend_reg    <= div_pend_next;
            div_gyro_reg    <= div_gyro_next;
            div_wr_reg      <= div_pend_reg;
            div_wr_gyro_reg <= div_gyro_reg;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_data_reg <= s_tdata;
            in_user_reg <= s_tuser;
        end
        if (fire) begin
            out_data_reg <= out_data_next;
            out_user_reg <= out_user_next;
        end
        div_prod_reg <= div_prod_next;
        div_neg_reg  <= div_neg_next;
    end

    // checks
    `IOC_ASSERT_IMP(a_no_fire_in_div, div_busy, !fire, "word processed while offsets update")
    `IOC_ASSERT_NXT(a_div_follows, fire && div_start, div_pend_reg && div_wr_reg == 1'b0, "divider not started after last sample")
    `IOC_ASSERT_IMP(a_gyro_idle_cnt, !g_flag_reg, g_cnt_reg == '0, "gyro counter running while idle")
    `IOC_ASSERT_IMP(a_accel_cnt_max, 1'b1, a_cnt_reg <= CNT_W'(CAL_SAMPLES), "accel counter past sample count")

endmodule

### dv/imu_offset_calibrator_tb.sv
module imu_offset_calibrator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import imu_oc_pkg::*;

    localparam int CLK_PERIOD   = 20;
    localparam int RANDOM_ITEMS = 600;
    localparam int HOLD_AFTER   = 350;
    localparam int HOLD_CYCLES  = 300;
    localparam int TAIL_CYCLES  = 8;
    localparam int TEMP_LSB     = 3 * AXIS_W;
    localparam int GYRO_LSB     = 3 * AXIS_W + TEMP_W;

    // bit patterns for the directed words
    localparam logic [15:0] EDGE_PATTERNS [6] = '{
        16'h0000, 16'h7FFF, 16'h8000, 16'hFFFF, 16'h5555, 16'hAAAA
    };
    // temperature values around the truncation points
    localparam int TEMP_EDGES [10] = '{
        0, -1, 339, 340, 341, -339, -340, -341, 32767, -32768
    };

    typedef enum int {RUN_GYRO, RUN_ACCEL, RUN_BOTH} run_kind_t;

    typedef struct {
        axis_t accel [3];
        axis_t temp_raw;
        axis_t gyro [3];
        logic  req_gyro;
        logic  req_accel;
    } imu_sample_t;

    typedef struct {
        axis_t                    accel [3];
        logic signed [TEMP_W-1:0] temp_c;
        axis_t                    gyro [3];
        logic                     gyro_busy;
        logic                     accel_busy;
    } imu_result_t;

    // offset tracking and expected result words, indexed by the tuser bit of each sensor
    class imu_calibration_model;
        axis_t       offset [2][3];
        sum_t        sums [2][3];
        cnt_t        count [2];
        bit          busy [2];
        int          cal_done [2];
        imu_result_t expected_q [$];
        int          samples;
        int          checked;
        int          errors;

        function new();
            for (int s = 0; s < 2; s++) begin
                count[s] = '0;
                busy[s] = 1'b0;
                cal_done[s] = 0;
                for (int i = 0; i < 3; i++) begin
                    offset[s][i] = '0;
                    sums[s][i] = '0;
                end
            end
            samples = 0;
            checked = 0;
            errors = 0;
        endfunction

        // one calibration step of one sensor, returns 1 when the accel step is skipped
        function bit advance_cal(int s, axis_t corr [3]);
            if (!busy[s]) return 1'b0;
            // first calibrating sample clears the offsets and sums
            if (count[s] == '0) begin
                for (int i = 0; i < 3; i++) begin
                    offset[s][i] = '0;
                    sums[s][i] = '0;
                end
                count[s] = cnt_t'(1);
                return 1'b1;
            end
            for (int i = 0; i < 3; i++) begin
                sums[s][i] = sums[s][i] + sum_t'(corr[i]);
            end
            // last sample: average, truncated toward zero
            if (count[s] == cnt_t'(CAL_SAMPLES)) begin
                for (int i = 0; i < 3; i++) begin
                    offset[s][i] = axis_t'(int'(sums[s][i]) / int'(count[s]));
                end
                count[s] = '0;
                busy[s] = 1'b0;
                cal_done[s]++;
                return 1'b1;
            end
            count[s] = count[s] + cnt_t'(1);
            return 1'b0;
        endfunction

        function void note_sample(imu_sample_t smp);
            imu_result_t r;
            // correction uses the offsets held before this word
            for (int i = 0; i < 3; i++) begin
                r.accel[i] = smp.accel[i] - offset[USER_ACCEL][i];
                r.gyro[i] = smp.gyro[i] - offset[USER_GYRO][i];
            end
            r.temp_c = TEMP_W'(int'(smp.temp_raw) / TEMP_DIV + TEMP_BIAS);
            if (smp.req_gyro) busy[USER_GYRO] = 1'b1;
            if (smp.req_accel) busy[USER_ACCEL] = 1'b1;
            // gyro first, its start and finish steps hold the accel back
            if (!advance_cal(USER_GYRO, r.gyro)) void'(advance_cal(USER_ACCEL, r.accel));
            r.gyro_busy = busy[USER_GYRO];
            r.accel_busy = busy[USER_ACCEL];
            expected_q.push_back(r);
            samples++;
        endfunction

        task report_mismatch(string what);
            $display("mismatch on result word %0d: %s", checked, what);
            errors++;
        endtask

        task check_result(logic [DATA_W-1:0] data, logic [USER_W-1:0] user);
            imu_result_t exp_r;
            if (expected_q.size() == 0) begin
                report_mismatch("result word arrived with nothing expected");
                return;
            end
            exp_r = expected_q.pop_front();
            checked++;
            for (int i = 0; i < 3; i++) begin
                if (data[i*AXIS_W +: AXIS_W] !== exp_r.accel[i])
                    report_mismatch($sformatf("accel[%0d] got %0d expected %0d", i,
                        $signed(data[i*AXIS_W +: AXIS_W]), exp_r.accel[i]));
                if (data[GYRO_LSB + i*AXIS_W +: AXIS_W] !== exp_r.gyro[i])
                    report_mismatch($sformatf("gyro[%0d] got %0d expected %0d", i,
                        $signed(data[GYRO_LSB + i*AXIS_W +: AXIS_W]), exp_r.gyro[i]));
            end
            if (data[TEMP_LSB +: TEMP_W] !== exp_r.temp_c)
                report_mismatch($sformatf("temperature got %0d expected %0d",
                    $signed(data[TEMP_LSB +: TEMP_W]), exp_r.temp_c));
            if (user[USER_GYRO] !== exp_r.gyro_busy)
                report_mismatch($sformatf("gyro busy got %b expected %b",
                    user[USER_GYRO], exp_r.gyro_busy));
            if (user[USER_ACCEL] !== exp_r.accel_busy)
                report_mismatch($sformatf("accel busy got %b expected %b",
                    user[USER_ACCEL], exp_r.accel_busy));
        endtask
    endclass

    logic              aclk = 1'b0;
    logic              aresetn;
    logic              s_tvalid;
    logic              s_tready;
    logic [DATA_W-1:0] s_tdata;
    logic [USER_W-1:0] s_tuser;
    logic              m_tvalid;
    logic              m_tready;
    logic [DATA_W-1:0] m_tdata;
    logic [USER_W-1:0] m_tuser;

    imu_calibration_model sb = new();

    imu_offset_calibrator DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // idle length, mostly none or short, a few long
    function automatic int idle_cycles();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // axis value around a bias, or anywhere in range for a negative spread
    function automatic axis_t axis_value(int bias, int spread);
        int v;
        if (spread < 0) return axis_t'($urandom_range(0, 16'hFFFF));
        v = bias + int'($urandom_range(0, 2 * spread)) - spread;
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return axis_t'(v);
    endfunction

    task automatic send_sample(imu_sample_t smp, int gap);
        logic [DATA_W-1:0] word;
        logic [USER_W-1:0] req;
        for (int i = 0; i < 3; i++) begin
            word[i*AXIS_W +: AXIS_W] = smp.accel[i];
            word[(4+i)*AXIS_W +: AXIS_W] = smp.gyro[i];
        end
        word[3*AXIS_W +: AXIS_W] = smp.temp_raw;
        req[USER_GYRO] = smp.req_gyro;
        req[USER_ACCEL] = smp.req_accel;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= word;
        s_tuser <= req;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_sample(smp);
    endtask

    // stop offering until every expected word has come back
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge aclk);
    endtask

    task automatic run_directed();
        imu_sample_t smp;
        smp.req_gyro = 1'b0;
        smp.req_accel = 1'b0;
        // all fields at the same bit pattern
        foreach (EDGE_PATTERNS[p]) begin
            for (int i = 0; i < 3; i++) begin
                smp.accel[i] = EDGE_PATTERNS[p];
                smp.gyro[i] = EDGE_PATTERNS[p];
            end
            smp.temp_raw = EDGE_PATTERNS[p];
            send_sample(smp, idle_cycles());
        end
        // temperature truncation edges with mixed axis patterns
        foreach (TEMP_EDGES[t]) begin
            for (int i = 0; i < 3; i++) begin
                smp.accel[i] = EDGE_PATTERNS[(t + i) % 6];
                smp.gyro[i] = EDGE_PATTERNS[(t + i + 3) % 6];
            end
            smp.temp_raw = axis_t'(TEMP_EDGES[t]);
            send_sample(smp, idle_cycles());
        end
    endtask

    // words with random content and no calibration request
    task automatic run_noise(int n);
        imu_sample_t smp;
        smp.req_gyro = 1'b0;
        smp.req_accel = 1'b0;
        for (int j = 0; j < n; j++) begin
            for (int i = 0; i < 3; i++) begin
                smp.accel[i] = axis_value(0, -1);
                smp.gyro[i] = axis_value(0, -1);
            end
            smp.temp_raw = axis_value(0, -1);
            send_sample(smp, idle_cycles());
        end
    endtask

    // one calibration from request until both sensors are idle again
    task automatic run_calibration(run_kind_t kind, bit extreme, bit force_overlap);
        int          bias [6];
        int          spread [6];
        int          other_at;
        int          n;
        bit          noisy;
        bit          full_rate;
        imu_sample_t smp;
        noisy = !extreme && ($urandom_range(0, 99) < 15);
        full_rate = ($urandom_range(0, 99) < 30);
        for (int k = 0; k < 6; k++) begin
            if (extreme) begin
                bias[k] = ($urandom_range(0, 1) != 0) ? 32767 : -32768;
                spread[k] = $urandom_range(0, 3);
            end else begin
                bias[k] = int'($urandom_range(0, 40000)) - 20000;
                spread[k] = noisy ? -1 : int'($urandom_range(0, 500));
            end
        end
        // the other sensor may be requested partway through
        other_at = -1;
        if (kind != RUN_BOTH && (force_overlap || $urandom_range(0, 99) < 40))
            other_at = $urandom_range(1, CAL_SAMPLES - 1);
        n = 0;
        do begin
            for (int i = 0; i < 3; i++) begin
                smp.accel[i] = axis_value(bias[i], spread[i]);
                smp.gyro[i] = axis_value(bias[3+i], spread[3+i]);
            end
            smp.temp_raw = axis_value(0, -1);
            smp.req_gyro = (n == 0) ? (kind != RUN_ACCEL) : (n == other_at && kind == RUN_ACCEL);
            smp.req_accel = (n == 0) ? (kind != RUN_GYRO) : (n == other_at && kind == RUN_GYRO);
            // repeated request while already busy
            if ($urandom_range(0, 99) < 3) begin
                smp.req_gyro |= sb.busy[USER_GYRO];
                smp.req_accel |= sb.busy[USER_ACCEL];
            end
            send_sample(smp, full_rate ? 0 : idle_cycles());
            n++;
        end while (sb.busy[USER_GYRO] || sb.busy[USER_ACCEL]);
    endtask

    task automatic run_random();
        int start;
        int runs;
        start = sb.samples;
        runs = 0;
        while (sb.samples < start + RANDOM_ITEMS) begin
            case (runs)
                0: run_calibration(RUN_BOTH, 1'b0, 1'b0);
                1: run_calibration(RUN_GYRO, 1'b1, 1'b0);
                2: run_calibration(RUN_ACCEL, 1'b1, 1'b1);
                default: run_calibration(run_kind_t'($urandom_range(0, 2)),
                                         $urandom_range(0, 99) < 20, 1'b0);
            endcase
            if (runs == 1) wait_drained();
            run_noise($urandom_range(10, 40));
            runs++;
        end
    endtask

    // result side: random stalls, clean bursts, one long hold-off
    initial begin : result_sink
        int stall;
        int clean_left;
        bit held;
        held = 1'b0;
        clean_left = 0;
        m_tready <= 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (!held && sb.checked >= HOLD_AFTER) begin
                held = 1'b1;
                stall = HOLD_CYCLES;
            end else if (clean_left > 0) begin
                clean_left--;
                stall = 0;
            end else begin
                stall = idle_cycles();
                if ($urandom_range(0, 99) < 4) clean_left = $urandom_range(20, 80);
            end
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            if (m_tvalid) sb.check_result(m_tdata, m_tuser);
        end
    end

    // sender side and end of run
    initial begin
        aresetn <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        s_tuser <= '0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        run_directed();
        wait_drained();
        run_random();
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (sb.expected_q.size() != 0)
            sb.report_mismatch($sformatf("%0d expected words never arrived",
                sb.expected_q.size()));
        $display("sent %0d sample words, finished %0d gyro and %0d accel offset calibrations",
            sb.samples, sb.cal_done[USER_GYRO], sb.cal_done[USER_ACCEL]);
        $display("compared %0d result words, %0d mismatches", sb.checked, sb.errors);
        if (sb.errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // watchdog
    initial begin
        #20ms;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

### imu_offset_calibrator.f
+incdir+sv
sv/imu_oc_pkg.sv
sv/imu_offset_calibrator.sv
dv/imu_offset_calibrator_tb.sv
